// File: hw/rtl/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared types and constants for the dual stereo looper: request and result
// payloads, command and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int LENGTH_BITS    = 20;
  localparam int WEIGHT_BITS    = 9;
  localparam int LOOP_DEPTH_DEF = 524288;

  // configuration register indexes
  localparam logic CFG_CROSSFADE_WEIGHT = 1'b0;
  localparam logic CFG_READ_STEP        = 1'b1;

  typedef enum logic [2:0] {
    OP_SAMPLE     = 3'd0,
    OP_REC_START  = 3'd1,
    OP_REC_STOP   = 3'd2,
    OP_DUB_TOGGLE = 3'd3,
    OP_LOOP_RESET = 3'd4,
    OP_SET_LENGTH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2,
    MODE_DUB  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ADDR,
    S_RD_WAIT,
    S_DIV,
    S_MIX,
    S_WR_CHK,
    S_DUB_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]                    op;
    logic                          loop_sel;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic [LENGTH_BITS-1:0]        new_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] l;
    logic signed [SAMPLE_BITS-1:0] r;
  } cell_t;

endpackage

// File: hw/rtl/dual_stereo_looper_core.sv
// Sample path: each loop is visited in turn; a silent loop is skipped, a playing loop's
// cell is read, and a loop whose position wraps runs a remainder division, one position
// bit per cycle (20 bits at default depth). Then the mixer runs and waits out any output
// stall; write-back then visits each loop, writing input into a recording loop and the
// halved sum into an overdubbing one; no new request is taken until it is done. Commands
// are handled in the idle state. Reset: synchronous; a clearing pass zeroes the store.
// ----------------------------------------------------------------------------
// dual_stereo_looper_core
// Two stereo loopers sharing one store, one subtractor and one multiplier
// under a small sequencer; crossfaded playback with overdub and record.
// ----------------------------------------------------------------------------
module dual_stereo_looper_core #(
  parameter int LOOP_DEPTH = dsl_pkg::LOOP_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dsl_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dsl_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [dsl_pkg::WEIGHT_BITS-1:0]  cfg_data
);

  localparam int SB        = dsl_pkg::SAMPLE_BITS;
  localparam int MEM_DEPTH = 2 * LOOP_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int POS_W     = $clog2(LOOP_DEPTH + 1);
  localparam int CNT_W     = $clog2(POS_W);
  localparam int ACC_W     = SB + 10;

  localparam logic [POS_W-1:0]  DEPTH_P   = POS_W'(LOOP_DEPTH);
  localparam logic [ADDR_W-1:0] B_BASE    = ADDR_W'(LOOP_DEPTH);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);
  localparam logic [31:0]       DEPTH32   = 32'(LOOP_DEPTH);
  localparam logic [dsl_pkg::WEIGHT_BITS-1:0] FULL_W = dsl_pkg::WEIGHT_BITS'(256);

  dsl_pkg::state_t state, state_next;

  // per-loop control
  dsl_pkg::mode_t   mode    [2];
  logic [POS_W-1:0] len     [2];
  logic [POS_W-1:0] pos     [2];
  logic [POS_W-1:0] rec_pos [2];
  logic             k;

  logic [dsl_pkg::WEIGHT_BITS-1:0] weight;
  logic                            step;

  // latched request
  logic signed [SB-1:0]            in_l, in_r;
  logic [dsl_pkg::WEIGHT_BITS-1:0] w_eff;
  logic                            stp;

  logic signed [SB-1:0] val_l [2];
  logic signed [SB-1:0] val_r [2];

  // remainder unit
  logic [POS_W-1:0] div_num;
  logic [POS_W-1:0] rem;
  logic [CNT_W-1:0] cnt;

  // mixer
  logic [2:0]              mix_cnt;
  logic signed [ACC_W-1:0] prod, acc_l, acc_r;

  logic [ADDR_W-1:0] clr_addr;

  // store
  dsl_pkg::cell_t mem [MEM_DEPTH];
  dsl_pkg::cell_t rd_data;
  logic           mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  dsl_pkg::cell_t mem_wdata;

  // combinational helpers
  dsl_pkg::mode_t   cur_mode;
  logic [POS_W-1:0] cur_len, cur_pos, cur_rec, step_sum, addr_pos, addr_p, rem_new;
  logic [POS_W:0]   cmp_a, diff;
  logic             ge, loop_on, dub_on, rec_on, out_free;
  logic [ADDR_W-1:0] loop_addr;
  logic signed [SB:0] sum_l, sum_r;
  logic [dsl_pkg::WEIGHT_BITS-1:0] mul_coef;
  logic signed [SB-1:0]   mul_x;
  logic signed [ACC_W-1:0] mul_result;
  logic                   accept;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cur_mode = mode[k];
    cur_len  = len[k];
    cur_pos  = pos[k];
    cur_rec  = rec_pos[k];
    loop_on  = (cur_len != '0) &&
               (cur_mode == dsl_pkg::MODE_PLAY || cur_mode == dsl_pkg::MODE_DUB);
    dub_on   = (cur_len != '0) && (cur_mode == dsl_pkg::MODE_DUB);
    rec_on   = (cur_mode == dsl_pkg::MODE_REC) && (cur_rec < DEPTH_P);

    // shared compare and subtract: wrap check, then one remainder bit a cycle
    step_sum = cur_pos + POS_W'(stp);
    cmp_a    = (state == dsl_pkg::S_DIV) ? {rem, div_num[POS_W-1]} : {1'b0, step_sum};
    diff     = cmp_a - {1'b0, cur_len};
    ge       = !diff[POS_W];
    rem_new  = ge ? diff[POS_W-1:0] : cmp_a[POS_W-1:0];

    addr_pos  = (state == dsl_pkg::S_WR_CHK && cur_mode == dsl_pkg::MODE_REC) ?
                cur_rec : cur_pos;
    addr_p    = (addr_pos >= DEPTH_P) ? DEPTH_P - POS_W'(1) : addr_pos;
    loop_addr = (k ? B_BASE : '0) + ADDR_W'(addr_p);
    mem_addr  = (state == dsl_pkg::S_CLEAR) ? clr_addr : loop_addr;

    sum_l = {rd_data.l[SB-1], rd_data.l} + {in_l[SB-1], in_l};
    sum_r = {rd_data.r[SB-1], rd_data.r} + {in_r[SB-1], in_r};

    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_wdata = '0;
    case (state)
      dsl_pkg::S_CLEAR: mem_we = 1'b1;
      dsl_pkg::S_RD_ADDR: mem_re = loop_on;
      dsl_pkg::S_WR_CHK: begin
        mem_re      = dub_on;
        mem_we      = rec_on;
        mem_wdata.l = in_l;
        mem_wdata.r = in_r;
      end
      dsl_pkg::S_DUB_WAIT: begin
        mem_we      = 1'b1;
        mem_wdata.l = sum_l[SB:1];
        mem_wdata.r = sum_r[SB:1];
      end
      default: ;
    endcase

    // mixer operand select: A left, B left, A right, B right
    mul_coef = mix_cnt[0] ? w_eff : FULL_W - w_eff;
    case (mix_cnt[1:0])
      2'd0:    mul_x = val_l[0];
      2'd1:    mul_x = val_l[1];
      2'd2:    mul_x = val_r[0];
      default: mul_x = val_r[1];
    endcase
    mul_result = ACC_W'($signed({1'b0, mul_coef})) * ACC_W'(mul_x);

    in_ready   = (state == dsl_pkg::S_IDLE);
    state_next = state;
    case (state)
      dsl_pkg::S_CLEAR:
        if (clr_addr == CLR_LAST) state_next = dsl_pkg::S_IDLE;
      dsl_pkg::S_IDLE:
        if (accept && in_data.op == dsl_pkg::OP_SAMPLE) state_next = dsl_pkg::S_RD_ADDR;
      dsl_pkg::S_RD_ADDR:
        if (loop_on) state_next = dsl_pkg::S_RD_WAIT;
        else if (k) state_next = dsl_pkg::S_MIX;
      dsl_pkg::S_RD_WAIT:
        if (ge) state_next = dsl_pkg::S_DIV;
        else state_next = k ? dsl_pkg::S_MIX : dsl_pkg::S_RD_ADDR;
      dsl_pkg::S_DIV:
        if (cnt == '0) state_next = k ? dsl_pkg::S_MIX : dsl_pkg::S_RD_ADDR;
      dsl_pkg::S_MIX:
        if (mix_cnt == 3'd5 && out_free) state_next = dsl_pkg::S_WR_CHK;
      dsl_pkg::S_WR_CHK:
        if (dub_on) state_next = dsl_pkg::S_DUB_WAIT;
        else if (k) state_next = dsl_pkg::S_IDLE;
      dsl_pkg::S_DUB_WAIT:
        state_next = k ? dsl_pkg::S_IDLE : dsl_pkg::S_WR_CHK;
      default: state_next = dsl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dsl_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        mode[i]    <= dsl_pkg::MODE_IDLE;
        len[i]     <= '0;
        pos[i]     <= '0;
        rec_pos[i] <= '0;
      end
      k         <= 1'b0;
      weight    <= '0;
      step      <= 1'b1;
      mix_cnt   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dsl_pkg::CFG_CROSSFADE_WEIGHT: weight <= cfg_data;
          dsl_pkg::CFG_READ_STEP:        step   <= cfg_data[0];
          default: ;
        endcase
      end

      // drop a taken result unless the mixer loads the next one now
      if (out_valid && out_ready && !(state == dsl_pkg::S_MIX && mix_cnt == 3'd5))
        out_valid <= 1'b0;

      case (state)
        dsl_pkg::S_CLEAR: clr_addr <= clr_addr + ADDR_W'(1);

        dsl_pkg::S_IDLE: begin
          k <= 1'b0;
          if (accept) begin
            case (in_data.op)
              dsl_pkg::OP_SAMPLE: begin
                in_l  <= in_data.sample_left;
                in_r  <= in_data.sample_right;
                w_eff <= (weight > FULL_W) ? FULL_W : weight;
                stp   <= step;
              end
              dsl_pkg::OP_REC_START: begin
                rec_pos[in_data.loop_sel] <= '0;
                mode[in_data.loop_sel]    <= dsl_pkg::MODE_REC;
              end
              dsl_pkg::OP_REC_STOP: begin
                len[in_data.loop_sel]  <= rec_pos[in_data.loop_sel];
                pos[in_data.loop_sel]  <= '0;
                mode[in_data.loop_sel] <= dsl_pkg::MODE_PLAY;
              end
              dsl_pkg::OP_DUB_TOGGLE: begin
                if (mode[in_data.loop_sel] == dsl_pkg::MODE_PLAY)
                  mode[in_data.loop_sel] <= dsl_pkg::MODE_DUB;
                else if (mode[in_data.loop_sel] == dsl_pkg::MODE_DUB)
                  mode[in_data.loop_sel] <= dsl_pkg::MODE_PLAY;
              end
              dsl_pkg::OP_LOOP_RESET: begin
                rec_pos[in_data.loop_sel] <= '0;
                pos[in_data.loop_sel]     <= '0;
                len[in_data.loop_sel]     <= '0;
                mode[in_data.loop_sel]    <= dsl_pkg::MODE_IDLE;
              end
              dsl_pkg::OP_SET_LENGTH: begin
                // saturate at the loop depth
                if (32'(in_data.new_length) > DEPTH32) len[in_data.loop_sel] <= DEPTH_P;
                else len[in_data.loop_sel] <= POS_W'(in_data.new_length);
              end
              default: ;
            endcase
          end
        end

        dsl_pkg::S_RD_ADDR: begin
          if (!loop_on) begin
            val_l[k] <= '0;
            val_r[k] <= '0;
            k        <= ~k;
          end
        end

        dsl_pkg::S_RD_WAIT: begin
          val_l[k] <= rd_data.l;
          val_r[k] <= rd_data.r;
          if (ge) begin
            div_num <= step_sum;
            rem     <= '0;
            cnt     <= CNT_W'(POS_W - 1);
          end else begin
            pos[k] <= step_sum;
            k      <= ~k;
          end
        end

        dsl_pkg::S_DIV: begin
          rem     <= rem_new;
          div_num <= {div_num[POS_W-2:0], 1'b0};
          cnt     <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            pos[k] <= rem_new;
            k      <= ~k;
          end
        end

        dsl_pkg::S_MIX: begin
          if (mix_cnt < 3'd4) prod <= mul_result;
          case (mix_cnt)
            3'd1: acc_l <= prod;
            3'd2: acc_l <= acc_l + prod;
            3'd3: acc_r <= prod;
            3'd4: acc_r <= acc_r + prod;
            default: ;
          endcase
          if (mix_cnt != 3'd5) begin
            mix_cnt <= mix_cnt + 3'd1;
          end else if (out_free) begin
            // floor divide by 256
            out_data.out_left  <= acc_l[SB+7:8];
            out_data.out_right <= acc_r[SB+7:8];
            out_valid          <= 1'b1;
            mix_cnt            <= '0;
          end
        end

        dsl_pkg::S_WR_CHK: begin
          if (rec_on) rec_pos[k] <= cur_rec + POS_W'(1);
          if (!dub_on) k <= ~k;
        end

        dsl_pkg::S_DUB_WAIT: k <= ~k;

        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/dsl_checker.sv
// ----------------------------------------------------------------------------
// dsl_checker
// Port-level checks for the dual stereo looper, bound to the top level.
// ----------------------------------------------------------------------------
module dsl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input dsl_pkg::in_item_t               in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input dsl_pkg::out_item_t              out_data
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // a sample request leaves the block busy in the cycle after it is taken
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op == dsl_pkg::OP_SAMPLE |=> !in_ready)
    else $error("ready right after a sample request");

  // after a command the block is ready again in the next cycle
  a_cmd_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.op != dsl_pkg::OP_SAMPLE |=> in_ready)
    else $error("command did not return to ready");

  // a result appears only while a sample request is in work
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready)
    else $error("result appeared while idle");

  // store clearing follows reset
  a_clear: assert property (@(posedge clk)
    $fell(rst) |-> !in_ready)
    else $error("ready during store clearing");

endmodule

bind dual_stereo_looper_core dsl_checker u_dsl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
